// ===== design/ioc_pkg.sv =====
// Package with the operation codes, status codes and control types of the ordered list.
package ioc_pkg;

    // Index width that covers every slot position for any supported capacity.
    localparam int IDX_W = 11;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_HEAD   = 3'd1,
        OP_TAIL   = 3'd2,
        OP_AT     = 3'd3,
        OP_DELETE = 3'd4
    } ioc_op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } ioc_status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             rd;
        logic [IDX_W-1:0] where;
    } ioc_ctl_t;

endpackage

// ===== design/indexed_ordered_list.sv =====
// Top level of the indexed ordered list: cell chain, decoder and result register.
//
//  Channel | Ports                      | Direction | Content
//  s_      | s_tvalid s_tready s_tdata  | in        | one operation per transfer
//  m_      | m_tvalid m_tready m_tdata  | out       | one result per operation
//
// All cells shift together, so an insert or delete costs the same as a read,
// and the result register is loaded at accept.
// A new transfer is taken each cycle while the result register is empty or being
// drained; a stalled m_ side holds the result and blocks further input.
// aresetn (synchronous, active low) clears the count and the result valid flag;
// the cells keep whatever they held and are only read below the count.
module indexed_ordered_list #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operation[2:0], position[9:3], item_value[25:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // read_value[15:0], status[17:16], entry_count[24:18]
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                    accept;
    ioc_pkg::ioc_ctl_t       ctl;
    ioc_pkg::ioc_status_t    status;
    logic [CW-1:0]           count_after;
    logic [VALUE_WIDTH-1:0]  new_value;
    logic [VALUE_WIDTH-1:0]  cell_value [CAPACITY];
    logic [VALUE_WIDTH-1:0]  cell_read  [CAPACITY];
    logic [VALUE_WIDTH-1:0]  read_bus;
    logic [15:0]             read_value;
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [31:0]             m_tdata_reg;
    logic [31:0]             m_tdata_next;

    // Input is taken whenever the result register is free or being emptied.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign new_value = VALUE_WIDTH'(32'(s_tdata[25:10]));

    ioc_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .operation   (s_tdata[2:0]),
        .position    (s_tdata[9:3]),
        .ctl         (ctl),
        .status      (status),
        .count_after (count_after)
    );

    // The chain of storage cells, each wired to its two neighbors.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic [VALUE_WIDTH-1:0] right_value;

        if (i == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_mid_l
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_mid_r
            assign right_value = cell_value[i+1];
        end

        ioc_cell #(
            .IDX         (i),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .new_value   (new_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .read_out    (cell_read[i])
        );
    end

    // Only the addressed cell drives a nonzero value, so the read bus is an OR.
    always_comb begin
        read_bus = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            read_bus = read_bus | cell_read[i];
        end
    end

    assign read_value = 16'(32'(read_bus));

    // Result register and its valid flag.
    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tdata_next  = {7'd0, 7'(32'(count_after)), status, read_value};
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/ioc_cell.sv =====
// One storage cell of the chain: holds a single entry and shifts with its neighbors.
module ioc_cell #(
    parameter int IDX         = 0,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   aclk,
    input  ioc_pkg::ioc_ctl_t      ctl,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [VALUE_WIDTH-1:0] read_out
);

    localparam logic [ioc_pkg::IDX_W-1:0] MY_IDX = ioc_pkg::IDX_W'(IDX);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;

    // Insert opens a gap at the target slot; delete pulls the right neighbor in.
    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (MY_IDX == ctl.where) begin
                data_next = new_value;
            end else if (MY_IDX > ctl.where) begin
                data_next = left_value;
            end
        end else if (ctl.del) begin
            if (MY_IDX >= ctl.where) begin
                data_next = right_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign value = data_reg;

    // The addressed cell drives the read bus; all others drive zero.
    assign read_out = (ctl.rd && (MY_IDX == ctl.where)) ? data_reg : '0;

endmodule

// ===== design/ioc_ctrl.sv =====
// Operation decoder and entry counter that steers the cell chain.
module ioc_ctrl #(
    parameter int CAPACITY = 64,
    parameter int CW       = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [2:0]           operation,
    input  logic [6:0]           position,
    output ioc_pkg::ioc_ctl_t    ctl,
    output ioc_pkg::ioc_status_t status,
    output logic [CW-1:0]        count_after
);

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [ioc_pkg::IDX_W-1:0]   pos_w;
    logic [ioc_pkg::IDX_W-1:0]   cnt_w;
    logic                        full;
    logic                        ins;
    logic                        del;
    logic                        rd;
    logic [ioc_pkg::IDX_W-1:0]   where;

    assign pos_w = ioc_pkg::IDX_W'(position);
    assign cnt_w = ioc_pkg::IDX_W'(count_reg);
    assign full  = (count_reg == CW'(CAPACITY));

    // Decode the operation against the current count.
    always_comb begin
        ins    = 1'b0;
        del    = 1'b0;
        rd     = 1'b0;
        where  = pos_w;
        status = ioc_pkg::ST_OK;
        case (ioc_pkg::ioc_op_t'(operation))
            ioc_pkg::OP_READ: begin
                if (pos_w < cnt_w) begin
                    rd = 1'b1;
                end else begin
                    status = ioc_pkg::ST_BADPOS;
                end
            end
            ioc_pkg::OP_HEAD: begin
                where = '0;
                if (full) begin
                    status = ioc_pkg::ST_FULL;
                end else begin
                    ins = 1'b1;
                end
            end
            ioc_pkg::OP_TAIL: begin
                where = cnt_w;
                if (full) begin
                    status = ioc_pkg::ST_FULL;
                end else begin
                    ins = 1'b1;
                end
            end
            ioc_pkg::OP_AT: begin
                if (pos_w > cnt_w) begin
                    status = ioc_pkg::ST_BADPOS;
                end else if (full) begin
                    status = ioc_pkg::ST_FULL;
                end else begin
                    ins = 1'b1;
                end
            end
            ioc_pkg::OP_DELETE: begin
                if (pos_w < cnt_w) begin
                    del = 1'b1;
                end else begin
                    status = ioc_pkg::ST_BADPOS;
                end
            end
            default: begin
                status = ioc_pkg::ST_BADPOS;
            end
        endcase
    end

    // Cells only move on an accepted transfer.
    assign ctl.ins   = ins & accept;
    assign ctl.del   = del & accept;
    assign ctl.rd    = rd;
    assign ctl.where = where;

    always_comb begin
        count_after = count_reg;
        if (ins) begin
            count_after = count_reg + CW'(1);
        end else if (del) begin
            count_after = count_reg - CW'(1);
        end
    end

    assign count_next = accept ? count_after : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== tb/sv/tb_indexed_ordered_list.sv =====
// Self-checking testbench for the indexed ordered list, with its own model of the store.
`timescale 1ns / 1ps

module tb_indexed_ordered_list;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_SLACK = 4;
    localparam int PHASE_ITEMS = 530;
    localparam int PAUSE_EVERY = 200;

    // Operation field values the block does not define.
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_CODE    = 3'd7;

    // Expected content of one result transfer.
    typedef struct packed {
        logic [15:0]          read_value;
        ioc_pkg::ioc_status_t status;
        logic [6:0]           entry_count;
    } list_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // operation[2:0], position[9:3], item_value[25:10]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // read_value[15:0], status[17:16], entry_count[24:18]

    // Shadow copy of the list and bookkeeping.
    logic [15:0]  shadow_entries [CAPACITY];
    int           shadow_count;
    list_result_t pending_results [$];
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           mismatches;
    int           results_checked;
    int           cycle_count;
    int           peak_count;
    int           status_tally [4];
    int           op_tally [8];
    bit           growing;

    indexed_ordered_list #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Applies one operation to the shadow list and returns the result it must produce.
    function automatic list_result_t apply_list_op(logic [2:0] op, logic [6:0] pos,
                                                   logic [15:0] val);
        list_result_t res;
        int slot;
        res.read_value = '0;
        res.status     = ioc_pkg::ST_OK;
        slot           = 0;
        case (op)
            ioc_pkg::OP_READ: begin
                if (pos < shadow_count) res.read_value = shadow_entries[pos];
                else res.status = ioc_pkg::ST_BADPOS;
            end
            ioc_pkg::OP_HEAD, ioc_pkg::OP_TAIL, ioc_pkg::OP_AT: begin
                if (op == ioc_pkg::OP_TAIL) slot = shadow_count;
                else if (op == ioc_pkg::OP_AT) slot = int'(pos);
                // A bad position outranks a full store.
                if (op == ioc_pkg::OP_AT && pos > shadow_count) begin
                    res.status = ioc_pkg::ST_BADPOS;
                end else if (shadow_count >= CAPACITY) begin
                    res.status = ioc_pkg::ST_FULL;
                end else begin
                    for (int i = shadow_count; i > slot; i--)
                        shadow_entries[i] = shadow_entries[i - 1];
                    shadow_entries[slot] = val;
                    shadow_count++;
                end
            end
            ioc_pkg::OP_DELETE: begin
                if (pos < shadow_count) begin
                    for (int i = int'(pos); i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                end else begin
                    res.status = ioc_pkg::ST_BADPOS;
                end
            end
            default: res.status = ioc_pkg::ST_BADPOS;
        endcase
        res.entry_count = shadow_count[6:0];
        if (shadow_count > peak_count) peak_count = shadow_count;
        status_tally[res.status]++;
        op_tally[op]++;
        return res;
    endfunction

    // Sends one operation, with an optional idle gap first, and records its result.
    task automatic send_op(logic [2:0] op, logic [6:0] pos, logic [15:0] val);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, val, pos, op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_list_op(op, pos, val));
    endtask

    // Holds the input side idle until every outstanding result has been checked.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Picks a random operation; mostly well-formed, leaning toward growth or shrinkage.
    task automatic send_random_op();
        logic [2:0] op;
        logic [6:0] pos;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
        else if (roll < 20) op = ioc_pkg::OP_READ;
        else if (roll < (growing ? 75 : 45))
            op = 3'($urandom_range(ioc_pkg::OP_HEAD, ioc_pkg::OP_AT));
        else op = ioc_pkg::OP_DELETE;

        if ($urandom_range(0, 99) < 15) pos = 7'($urandom);
        else if (op == ioc_pkg::OP_AT) pos = 7'($urandom_range(0, shadow_count));
        else if (shadow_count > 0) pos = 7'($urandom_range(0, shadow_count - 1));
        else pos = '0;

        send_op(op, pos, 16'($urandom));
    endtask

    // Operations on an empty store, including the undefined operation codes.
    task automatic test_empty_store();
        send_op(ioc_pkg::OP_READ, 7'd0, 16'h0000);
        send_op(ioc_pkg::OP_READ, 7'h7F, 16'hFFFF);
        send_op(ioc_pkg::OP_DELETE, 7'd0, 16'h0000);
        send_op(ioc_pkg::OP_AT, 7'd1, 16'hFFFF);
        for (int code = OP_FIRST_UNUSED; code <= OP_LAST_CODE; code++)
            send_op(3'(code), 7'h7F, 16'hFFFF);
    endtask

    // Each insert flavor at the head, tail, middle and end, read back and trimmed.
    task automatic test_insert_ops();
        send_op(ioc_pkg::OP_HEAD, 7'h7F, 16'hFFFF);
        send_op(ioc_pkg::OP_TAIL, 7'd0, 16'h0000);
        send_op(ioc_pkg::OP_AT, 7'd1, 16'h1234);
        send_op(ioc_pkg::OP_AT, 7'd3, 16'h8001);
        send_op(ioc_pkg::OP_AT, 7'd5, 16'hAAAA);
        for (int i = 0; i <= 4; i++)
            send_op(ioc_pkg::OP_READ, 7'(i), 16'h5555);
        send_op(ioc_pkg::OP_DELETE, 7'd1, 16'h0000);
        send_op(ioc_pkg::OP_READ, 7'd1, 16'h0000);
    endtask

    // Fills the store with random inserts, then probes the insert and read refusals at the limit.
    task automatic test_full_store();
        while (shadow_count < CAPACITY)
            send_op(3'($urandom_range(ioc_pkg::OP_HEAD, ioc_pkg::OP_AT)),
                    7'($urandom_range(0, shadow_count)), 16'($urandom));
        send_op(ioc_pkg::OP_HEAD, 7'd0, 16'hFFFF);
        send_op(ioc_pkg::OP_TAIL, 7'd0, 16'hFFFF);
        send_op(ioc_pkg::OP_AT, 7'(CAPACITY), 16'hFFFF);
        send_op(ioc_pkg::OP_AT, 7'(CAPACITY + 1), 16'hFFFF);
        send_op(ioc_pkg::OP_READ, 7'(CAPACITY - 1), 16'h0000);
        send_op(ioc_pkg::OP_READ, 7'(CAPACITY), 16'h0000);
        send_op(ioc_pkg::OP_DELETE, 7'(CAPACITY - 1), 16'h0000);
        send_op(ioc_pkg::OP_DELETE, 7'd0, 16'h0000);
        send_op(ioc_pkg::OP_TAIL, 7'd0, 16'hC3C3);
    endtask

    // Random traffic that swings the fill level between nearly empty and full.
    task automatic test_random_traffic(int n_items);
        for (int n = 0; n < n_items; n++) begin
            if (shadow_count >= CAPACITY) growing = 1'b0;
            else if (shadow_count <= 2) growing = 1'b1;
            if (n % PAUSE_EVERY == PAUSE_EVERY - 1) wait_for_results();
            send_random_op();
        end
    endtask

    // Receiver stalls at random at the current rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Compares each result transfer with the oldest expected one.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tdata[15:0] !== want.read_value) begin
                    $display("%0t: read_value expected %h, actual %h",
                             $time, want.read_value, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[17:16] !== want.status) begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, m_tdata[17:16]);
                    mismatches++;
                end
                if (m_tdata[24:18] !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d, actual %0d",
                             $time, want.entry_count, m_tdata[24:18]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("** indexed_ordered_list: FAILED **");
        $finish;
    end

    // Test sequence.
    initial begin
        shadow_count    = 0;
        peak_count      = 0;
        mismatches      = 0;
        results_checked = 0;
        growing         = 1'b1;
        tx_idle_pct     = 21;
        rx_idle_pct     = 49;
        foreach (status_tally[i]) status_tally[i] = 0;
        foreach (op_tally[i]) op_tally[i] = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_store();
        test_insert_ops();
        test_full_store();
        wait_for_results();

        test_random_traffic(PHASE_ITEMS);
        tx_idle_pct = 49;
        rx_idle_pct = 21;
        test_random_traffic(PHASE_ITEMS);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(PHASE_ITEMS);

        wait_for_results();
        repeat (DRAIN_SLACK) @(posedge aclk);

        $display("Checked %0d results; fill level peaked at %0d of %0d entries.",
                 results_checked, peak_count, CAPACITY);
        $display("Outcomes: %0d ok, %0d bad position, %0d refused as full; %0d undefined ops.",
                 status_tally[ioc_pkg::ST_OK], status_tally[ioc_pkg::ST_BADPOS],
                 status_tally[ioc_pkg::ST_FULL],
                 op_tally[OP_FIRST_UNUSED] + op_tally[OP_FIRST_UNUSED + 3'd1] +
                 op_tally[OP_LAST_CODE]);
        if (mismatches == 0) begin
            $display("** indexed_ordered_list: PASSED **");
        end else begin
            $display("** indexed_ordered_list: FAILED **");
        end
        $finish;
    end

endmodule

// ===== indexed_ordered_list.f =====
design/ioc_pkg.sv
design/ioc_cell.sv
design/ioc_ctrl.sv
design/indexed_ordered_list.sv
tb/sv/tb_indexed_ordered_list.sv
